@@ sv/rllt_pkg.sv @@
// Shared widths, operation codes and controller/datapath interface types.
package rllt_pkg;

    localparam int POS_W  = 12;
    localparam int LINE_W = 16;

    localparam int POSITION_DEPTH_DEF = 4096;
    localparam int RUN_DEPTH_DEF      = 256;

    localparam logic FUNC_APPEND = 1'b0;
    localparam logic FUNC_QUERY  = 1'b1;

    typedef struct packed {
        logic capture;
        logic append;
        logic walk;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic walk_done;
    } t_dp_stat;

endpackage

@@ sv/run_length_line_table.sv @@
// Sequence: an append passes the append and done states; a query walks the stored runs in
// order, up to the covering run, or all runs on a miss; the done state waits for a free output.
// Throughput: one item at a time; the walk reads one run per cycle through the single
// read port of the run store.
// Reset (synchronous, active low) empties the table; the run store itself is not cleared.
// Top level of the run-length line table: controller plus datapath.
module run_length_line_table #(
    parameter int POSITION_DEPTH = rllt_pkg::POSITION_DEPTH_DEF,
    parameter int RUN_DEPTH      = rllt_pkg::RUN_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic                        i_func,
    input  logic [rllt_pkg::LINE_W-1:0] i_src_line,
    input  logic [rllt_pkg::POS_W-1:0]  i_query_index,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [rllt_pkg::POS_W-1:0]  o_position,
    output logic [rllt_pkg::LINE_W-1:0] o_found_line,
    output logic                        o_found,
    output logic                        o_rejected
);
    import rllt_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    rllt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_func  (i_func),
        .i_ready (i_ready),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .o_cmd   (cmd),
        .i_stat  (stat)
    );

    rllt_datapath #(
        .POSITION_DEPTH (POSITION_DEPTH),
        .RUN_DEPTH      (RUN_DEPTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_src_line    (i_src_line),
        .i_query_index (i_query_index),
        .o_position    (o_position),
        .o_found_line  (o_found_line),
        .o_found       (o_found),
        .o_rejected    (o_rejected)
    );

endmodule

@@ sv/rllt_ctrl.sv @@
// Sequencing state machine and output valid for the run-length line table.
module rllt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_func,
    input  logic              i_ready,
    output logic              o_ready,
    output logic              o_valid,
    output rllt_pkg::t_dp_cmd o_cmd,
    input  rllt_pkg::t_dp_stat i_stat
);
    import rllt_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_APPEND = 4'b0010,
        S_WALK   = 4'b0100,
        S_DONE   = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   accept;
    logic   out_free;

    assign o_ready  = (r_state == S_IDLE);
    assign accept   = i_valid && o_ready;
    assign out_free = !r_out_valid || i_ready;
    assign o_valid  = r_out_valid;

    always_comb begin
        n_state        = r_state;
        o_cmd.capture  = accept;
        o_cmd.append   = 1'b0;
        o_cmd.walk     = 1'b0;
        o_cmd.load_out = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = (i_func == FUNC_QUERY) ? S_WALK : S_APPEND;
                end
            end
            S_APPEND: begin
                o_cmd.append = 1'b1;
                n_state      = S_DONE;
            end
            S_WALK: begin
                o_cmd.walk = 1'b1;
                if (i_stat.walk_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // hold the result until the output register frees up
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid && !i_ready;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

@@ sv/rllt_datapath.sv @@
// Run store, totals, query walker and result registers.
module rllt_datapath #(
    parameter int POSITION_DEPTH = rllt_pkg::POSITION_DEPTH_DEF,
    parameter int RUN_DEPTH      = rllt_pkg::RUN_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  rllt_pkg::t_dp_cmd           i_cmd,
    output rllt_pkg::t_dp_stat          o_stat,
    input  logic [rllt_pkg::LINE_W-1:0] i_src_line,
    input  logic [rllt_pkg::POS_W-1:0]  i_query_index,
    output logic [rllt_pkg::POS_W-1:0]  o_position,
    output logic [rllt_pkg::LINE_W-1:0] o_found_line,
    output logic                        o_found,
    output logic                        o_rejected
);
    import rllt_pkg::*;

    localparam int CNT_W = $clog2(POSITION_DEPTH + 1);
    localparam int RT_W  = $clog2(RUN_DEPTH + 1);
    localparam int RI_W  = $clog2(RUN_DEPTH);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int WRD_W = LINE_W + CNT_W;

    // each entry holds {line, count}
    logic [WRD_W-1:0] r_mem [RUN_DEPTH];
    logic [WRD_W-1:0] r_rd_data;

    logic [RT_W-1:0]   r_run_total;
    logic [CNT_W-1:0]  r_item_total;
    logic [LINE_W-1:0] r_last_line;
    logic [CNT_W-1:0]  r_last_count;

    logic [LINE_W-1:0] r_line;
    logic [POS_W-1:0]  r_idx;
    logic [CNT_W-1:0]  r_sum;
    logic [RT_W-1:0]   r_addr;
    logic              r_rd_pend;

    logic [POS_W-1:0]  r_res_pos;
    logic [LINE_W-1:0] r_res_line;
    logic              r_res_found;
    logic              r_res_rej;

    logic [POS_W-1:0]  r_out_pos;
    logic [LINE_W-1:0] r_out_line;
    logic              r_out_found;
    logic              r_out_rej;

    logic              pos_full;
    logic              run_full;
    logic              extend;
    logic [RT_W-1:0]   last_idx;
    logic              mem_we;
    logic [RI_W-1:0]   mem_waddr;
    logic [WRD_W-1:0]  mem_wdata;
    logic              take;

    logic              more;
    logic              issue;
    logic [CNT_W-1:0]  rd_count;
    logic [LINE_W-1:0] rd_line;
    logic [CNT_W-1:0]  sum_next;
    logic              hit;
    logic              done;

    // append decision
    assign pos_full = (r_item_total >= CNT_W'(POSITION_DEPTH));
    assign run_full = (r_run_total >= RT_W'(RUN_DEPTH));
    assign extend   = (r_run_total != '0) && (r_last_line == r_line);
    assign last_idx = r_run_total - RT_W'(1);
    assign take     = !pos_full && (extend || !run_full);

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_run_total[RI_W-1:0];
        mem_wdata = {r_line, CNT_W'(1)};
        if (i_cmd.append && take) begin
            mem_we = 1'b1;
            if (extend) begin
                mem_waddr = last_idx[RI_W-1:0];
                mem_wdata = {r_last_line, r_last_count + CNT_W'(1)};
            end
        end
    end

    // query walk: issue one read per cycle, check the previous read's run
    assign more     = (r_addr < r_run_total);
    assign issue    = i_cmd.walk && more;
    assign rd_count = r_rd_data[CNT_W-1:0];
    assign rd_line  = r_rd_data[WRD_W-1:CNT_W];
    assign sum_next = r_sum + rd_count;
    assign hit      = r_rd_pend && (CMP_W'(r_idx) < CMP_W'(sum_next));
    assign done     = i_cmd.walk && (hit || (!r_rd_pend && !more));

    assign o_stat.walk_done = done;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (issue) begin
            r_rd_data <= r_mem[r_addr[RI_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_total  <= '0;
            r_item_total <= '0;
            r_rd_pend    <= 1'b0;
        end else begin
            if (i_cmd.capture) begin
                r_rd_pend <= 1'b0;
            end else if (i_cmd.walk) begin
                r_rd_pend <= issue;
            end
            if (i_cmd.append && take) begin
                r_item_total <= r_item_total + CNT_W'(1);
                if (!extend) begin
                    r_run_total <= r_run_total + RT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_line <= i_src_line;
            r_idx  <= i_query_index;
            r_sum  <= '0;
            r_addr <= '0;
        end
        if (i_cmd.walk) begin
            if (issue) begin
                r_addr <= r_addr + RT_W'(1);
            end
            if (r_rd_pend) begin
                r_sum <= sum_next;
            end
            if (done) begin
                r_res_pos   <= '0;
                r_res_line  <= hit ? rd_line : '0;
                r_res_found <= hit;
                r_res_rej   <= 1'b0;
            end
        end
        if (i_cmd.append) begin
            r_res_pos   <= take ? POS_W'(r_item_total) : '0;
            r_res_line  <= '0;
            r_res_found <= 1'b0;
            r_res_rej   <= !take;
            if (take) begin
                r_last_line  <= r_line;
                r_last_count <= extend ? r_last_count + CNT_W'(1) : CNT_W'(1);
            end
        end
        if (i_cmd.load_out) begin
            r_out_pos   <= r_res_pos;
            r_out_line  <= r_res_line;
            r_out_found <= r_res_found;
            r_out_rej   <= r_res_rej;
        end
    end

    assign o_position   = r_out_pos;
    assign o_found_line = r_out_line;
    assign o_found      = r_out_found;
    assign o_rejected   = r_out_rej;

endmodule

@@ sv/rllt_checker.sv @@
// Port-level checks on the run-length line table, bound to the top level.
module rllt_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_valid,
    input logic                        o_ready,
    input logic                        i_func,
    input logic [rllt_pkg::LINE_W-1:0] i_src_line,
    input logic [rllt_pkg::POS_W-1:0]  i_query_index,
    input logic                        o_valid,
    input logic                        i_ready,
    input logic [rllt_pkg::POS_W-1:0]  o_position,
    input logic [rllt_pkg::LINE_W-1:0] o_found_line,
    input logic                        o_found,
    input logic                        o_rejected
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_position) && $stable(o_found_line)
            && $stable(o_found) && $stable(o_rejected))
        else $error("result changed while stalled");

    // a query hit is never a rejected append and carries no position
    a_found_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_found |-> !o_rejected && (o_position == '0))
        else $error("found result carries append fields");

    // a rejected append reports nothing else
    a_reject_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_rejected |-> (o_position == '0) && (o_found_line == '0))
        else $error("rejected result carries data");

    // no line is reported without a hit
    a_line_needs_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_found |-> (o_found_line == '0))
        else $error("line reported without hit");

endmodule

bind run_length_line_table rllt_checker u_rllt_checker (.*);
